@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of the deque block.
// Depends on nothing; the including file supplies aclk and aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define DEQ_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("deque assertion failed");

// Checked on every clock edge, reset included.
`define DEQ_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("deque assertion failed during reset");

`endif

@@ src/deq_pkg.sv @@
// Package for the double-ended queue: command codes, field widths and
// the result metadata record. Depends on nothing.
`timescale 1ns / 1ps

package deq_pkg;

    localparam int WORD_W = 32;
    localparam int OCC_W  = 5;

    localparam logic signed [WORD_W-1:0] UNDERFLOW_WORD = -32'sd1;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic             pop_ok;
        logic             underflow;
        logic             overflow;
        logic [OCC_W-1:0] occupancy;
    } meta_t;

endpackage

@@ src/deq_store.sv @@
// Single-port synchronous word store for the deque with a registered read port.
// Depends on deq_pkg for the word width.
`timescale 1ns / 1ps

module deq_store #(
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic                                   rd_en,
    input  logic [$clog2(DEPTH)-1:0]               addr,
    input  logic signed [deq_pkg::WORD_W-1:0]      wr_data,
    output logic signed [deq_pkg::WORD_W-1:0]      rd_data
);

    logic signed [deq_pkg::WORD_W-1:0] mem [DEPTH];
    logic signed [deq_pkg::WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/double_ended_queue_top.sv @@
// Channel   Direction  Fields
// s_        in         cmd, push_value
// m_        out        pop_value, underflow, overflow, occupancy
//
// One transaction is accepted per cycle while s_ready is high.
// The latency comes from the store's registered read port plus the output register.
// A push writes the store and a pop reads it in the cycle of acceptance.
// Reset clears the front index, the count and both stage valids; the store is not cleared.
// A stalled result holds the output register and, one transaction later, the input.
// Top level of the double-ended queue. Depends on deq_pkg and deq_store.
`timescale 1ns / 1ps

module double_ended_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_cmd,
    input  logic signed [deq_pkg::WORD_W-1:0]   s_push_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [deq_pkg::WORD_W-1:0]   m_pop_value,
    output logic                                m_underflow,
    output logic                                m_overflow,
    output logic [deq_pkg::OCC_W-1:0]           m_occupancy
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = $clog2(2 * DEPTH);

    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             s1_valid_reg;
    deq_pkg::meta_t   s1_meta_reg, s1_meta_next;

    logic                              out_valid_reg;
    logic signed [deq_pkg::WORD_W-1:0] out_value_reg, out_value_next;
    deq_pkg::meta_t                    out_meta_reg;

    deq_pkg::cmd_t    cmd;
    logic             s_accept, out_load, full, empty;
    logic [IDX_W-1:0] front_dec, front_inc, back_slot, tail_slot, mem_addr;
    logic [SUM_W-1:0] sum, sum_dec;
    logic             mem_we, mem_re;
    logic signed [deq_pkg::WORD_W-1:0] rd_data;

    assign cmd      = deq_pkg::cmd_t'(s_cmd);
    assign out_load = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || out_load;
    assign s_accept = s_valid && s_ready;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign sum       = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign sum_dec   = sum - 1'b1;
    assign tail_slot = (sum >= SUM_W'(DEPTH)) ? IDX_W'(sum - SUM_W'(DEPTH)) : IDX_W'(sum);
    assign back_slot = (sum_dec >= SUM_W'(DEPTH)) ?
                       IDX_W'(sum_dec - SUM_W'(DEPTH)) : IDX_W'(sum_dec);

    always_comb begin
        front_next   = front_reg;
        count_next   = count_reg;
        mem_addr     = front_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        s1_meta_next = '0;
        unique case (cmd)
            deq_pkg::CMD_PUSH_FRONT: begin
                if (full) begin
                    s1_meta_next.overflow = 1'b1;
                end else begin
                    front_next = front_dec;
                    count_next = count_reg + 1'b1;
                    mem_addr   = front_dec;
                    mem_we     = s_accept;
                end
            end
            deq_pkg::CMD_PUSH_BACK: begin
                if (full) begin
                    s1_meta_next.overflow = 1'b1;
                end else begin
                    count_next = count_reg + 1'b1;
                    mem_addr   = tail_slot;
                    mem_we     = s_accept;
                end
            end
            deq_pkg::CMD_POP_FRONT: begin
                if (empty) begin
                    s1_meta_next.underflow = 1'b1;
                end else begin
                    front_next          = front_inc;
                    count_next          = count_reg - 1'b1;
                    mem_addr            = front_reg;
                    mem_re              = s_accept;
                    s1_meta_next.pop_ok = 1'b1;
                end
            end
            deq_pkg::CMD_POP_BACK: begin
                if (empty) begin
                    s1_meta_next.underflow = 1'b1;
                end else begin
                    count_next          = count_reg - 1'b1;
                    mem_addr            = back_slot;
                    mem_re              = s_accept;
                    s1_meta_next.pop_ok = 1'b1;
                end
            end
            default: begin
                s1_meta_next = '0;
            end
        endcase
        s1_meta_next.occupancy = deq_pkg::OCC_W'(count_next);
    end

    deq_store #(
        .DEPTH (DEPTH)
    ) u_deq_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .rd_en   (mem_re),
        .addr    (mem_addr),
        .wr_data (s_push_value),
        .rd_data (rd_data)
    );

    always_comb begin
        if (s1_meta_reg.pop_ok) begin
            out_value_next = rd_data;
        end else if (s1_meta_reg.underflow) begin
            out_value_next = deq_pkg::UNDERFLOW_WORD;
        end else begin
            out_value_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg     <= '0;
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_meta_reg <= s1_meta_next;
        end
        if (out_load) begin
            out_value_reg <= out_value_next;
            out_meta_reg  <= s1_meta_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_pop_value = out_value_reg;
    assign m_underflow = out_meta_reg.underflow;
    assign m_overflow  = out_meta_reg.overflow;
    assign m_occupancy = out_meta_reg.occupancy;

endmodule

@@ src/deq_checker.sv @@
// Port-level checker for the double-ended queue and its bind statement.
// Depends on assert_macros.svh, deq_pkg and double_ended_queue_top.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module deq_checker #(
    parameter int DEPTH = 16
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic [1:0]                          s_cmd,
    input logic signed [deq_pkg::WORD_W-1:0]   s_push_value,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [deq_pkg::WORD_W-1:0]   m_pop_value,
    input logic                                m_underflow,
    input logic                                m_overflow,
    input logic [deq_pkg::OCC_W-1:0]           m_occupancy
);

    logic [deq_pkg::WORD_W+1:0]               s_payload;
    logic [deq_pkg::WORD_W+deq_pkg::OCC_W+1:0] m_payload;
    logic                                     underflow_ok;
    logic                                     overflow_ok;

    assign s_payload    = {s_cmd, s_push_value};
    assign m_payload    = {m_pop_value, m_underflow, m_overflow, m_occupancy};
    assign underflow_ok = (m_pop_value == deq_pkg::UNDERFLOW_WORD) && (m_occupancy == '0) &&
                          !m_overflow;
    assign overflow_ok  = (m_occupancy == deq_pkg::OCC_W'(DEPTH)) && (m_pop_value == '0);

    `DEQ_ASSERT(a_input_held, s_valid && !s_ready |=> s_valid && $stable(s_payload))
    `DEQ_ASSERT(a_result_held, m_valid && !m_ready |=> m_valid && $stable(m_payload))
    `DEQ_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_valid)
    `DEQ_ASSERT(a_underflow_empty, m_valid && m_underflow |-> underflow_ok)
    `DEQ_ASSERT(a_overflow_full, m_valid && m_overflow |-> overflow_ok)

endmodule

bind double_ended_queue_top deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);
